/* rtl/hop_channel_map_selector_defines.svh */
// Assertion macros shared by the RTL of the hop channel map selector.
`ifndef HOP_CHANNEL_MAP_SELECTOR_DEFINES_SVH
`define HOP_CHANNEL_MAP_SELECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCMS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/hcms_pkg.sv */
package hcms_pkg;

	localparam int DVD_W     = 32;
	localparam int DIV_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam logic [2:0] MODE_HOP        = 3'd0;
	localparam logic [2:0] MODE_GOOD       = 3'd1;
	localparam logic [2:0] MODE_BAD_LOCAL  = 3'd2;
	localparam logic [2:0] MODE_BAD_REMOTE = 3'd3;
	localparam logic [2:0] MODE_MERGE      = 3'd4;
	localparam logic [2:0] MODE_READ_SHARE = 3'd5;

	localparam logic [1:0] ST_GOOD       = 2'd0;
	localparam logic [1:0] ST_BAD_LOCAL  = 2'd1;
	localparam logic [1:0] ST_BAD_REMOTE = 2'd2;
	localparam logic [1:0] ST_BAD_BOTH   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_HOP_INTERVAL     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOP_SEED         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_IN_USE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_CHANNEL = 2'd3;

	typedef struct packed {
		logic [2:0]  mode;
		logic [16:0] shared_time;
		logic [9:0]  channel;
		logic        remote_good;
	} in_item_t;

	typedef struct packed {
		logic [9:0] selected_channel;
		logic       found_good;
		logic [1:0] channel_status;
		logic       share_bit;
		logic       ignored;
	} out_item_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_QUO_WAIT,
		S_MOD_WAIT,
		S_SCAN,
		S_FB_READ,
		S_FB_CHECK,
		S_UPDATE,
		S_EMIT
	} state_t;

endpackage

/* rtl/hcms_divider.sv */
module hcms_divider
	import hcms_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient,
	output logic [DIV_W-1:0] remainder
);

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsr_q;

	logic [DIV_W:0]   shifted;
	logic [DIV_W+1:0] diff;
	logic             take;
	logic [DIV_W-1:0] rem_next;

	always_comb begin
		shifted  = {rem_q, quo_q[DVD_W-1]};
		diff     = {1'b0, shifted} - {2'b00, dsr_q};
		take     = !diff[DIV_W+1];
		rem_next = take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q && start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], take};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* rtl/hop_channel_map_selector.sv */
// Hop channel map selector.
// Input transactions arrive on in_valid/in_ready with an in_item_t payload. Each one
// produces exactly one out_item_t transaction on out_valid/out_ready.
// Registers are written over cfg_valid/cfg_ready with cfg_index and cfg_data; the
// port accepts writes only while no item is in progress.
// A hop select runs two 32-step divisions on one shared divider (quotient by the
// hop interval, then modulo the channel count), then scans the status memory at one
// entry per cycle. Mark, merge and read items take one memory read and one write.
// Unknown modes and out of range channels go straight from dispatch to emit, marked ignored.
// After reset the status memory is cleared to good by a pass over all MAX_CHANNELS entries,
// and in_ready stays low until it is done; configuration writes are taken meanwhile.
// The result sits in an output register. A new item is accepted while it waits, but
// that item's result is held back until the receiver has taken the previous one.
`include "hop_channel_map_selector_defines.svh"

module hop_channel_map_selector
	import hcms_pkg::*;
#(
	parameter int MAX_CHANNELS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int AW   = $clog2(MAX_CHANNELS);
	localparam int NW   = $clog2(MAX_CHANNELS + 1);
	localparam int CMPW = (NW > 11) ? NW : 11;

	state_t state_q, state_d;

	logic [15:0] hop_interval_q;
	logic [31:0] hop_seed_q;
	logic [10:0] channels_in_use_q;
	logic [9:0]  fallback_channel_q;

	in_item_t  item_q;
	out_item_t res_q, res_d, out_q;
	logic      res_we;
	logic      out_valid_q;
	logic      emit_load;

	logic [1:0] mem [MAX_CHANNELS];
	logic [1:0] rd_data_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic       wr_en;
	logic [1:0] wr_data;

	logic [AW-1:0] clr_idx_q, clr_idx_d;
	logic [AW-1:0] issue_idx_q, issue_idx_d, issue_idx_inc;
	logic [NW-1:0] issue_cnt_q, issue_cnt_d;
	logic          chk_vld_s1, chk_vld_d;
	logic [AW-1:0] chk_idx_s1;

	logic [NW-1:0] n_eff;
	logic [15:0]   interval_eff;
	logic [AW-1:0] ch_addr, fb_addr;
	logic          ch_out_of_range, fb_in_range;
	logic [1:0]    upd_st;

	logic             div_start, div_done;
	logic [DVD_W-1:0] div_dividend, div_quotient;
	logic [DIV_W-1:0] div_divisor, div_remainder;

	hcms_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quotient),
		.remainder (div_remainder)
	);

	always_comb begin
		if (channels_in_use_q == 11'd0) begin
			n_eff = NW'(1);
		end else if (CMPW'(channels_in_use_q) > CMPW'(MAX_CHANNELS)) begin
			n_eff = NW'(MAX_CHANNELS);
		end else begin
			n_eff = NW'(channels_in_use_q);
		end
		interval_eff    = (hop_interval_q == 16'd0) ? 16'd1 : hop_interval_q;
		ch_addr         = AW'(item_q.channel);
		fb_addr         = AW'(fallback_channel_q);
		ch_out_of_range = CMPW'(item_q.channel) >= CMPW'(n_eff);
		fb_in_range     = CMPW'(fallback_channel_q) < CMPW'(n_eff);
		if ((AW + 1)'(issue_idx_q) + (AW + 1)'(1) == (AW + 1)'(n_eff)) begin
			issue_idx_inc = '0;
		end else begin
			issue_idx_inc = issue_idx_q + AW'(1);
		end
	end

	always_comb begin
		upd_st = rd_data_q;
		case (item_q.mode)
			MODE_GOOD:       upd_st = ST_GOOD;
			MODE_BAD_LOCAL:  upd_st = (rd_data_q == ST_BAD_REMOTE) ? ST_BAD_BOTH : ST_BAD_LOCAL;
			MODE_BAD_REMOTE: upd_st = (rd_data_q == ST_BAD_LOCAL) ? ST_BAD_BOTH : ST_BAD_REMOTE;
			MODE_MERGE: begin
				if (!item_q.remote_good) begin
					if (rd_data_q == ST_GOOD) begin
						upd_st = ST_BAD_REMOTE;
					end else if (rd_data_q == ST_BAD_LOCAL) begin
						upd_st = ST_BAD_BOTH;
					end
				end
			end
			default: upd_st = rd_data_q;
		endcase
	end

	always_comb begin
		state_d      = state_q;
		rd_addr      = issue_idx_q;
		wr_en        = 1'b0;
		wr_addr      = clr_idx_q;
		wr_data      = ST_GOOD;
		div_start    = 1'b0;
		div_dividend = DVD_W'(item_q.shared_time);
		div_divisor  = interval_eff;
		res_we       = 1'b0;
		res_d        = '0;
		clr_idx_d    = clr_idx_q;
		issue_idx_d  = issue_idx_q;
		issue_cnt_d  = issue_cnt_q;
		chk_vld_d    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en     = 1'b1;
				clr_idx_d = clr_idx_q + AW'(1);
				if (clr_idx_q == AW'(MAX_CHANNELS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				rd_addr = ch_addr;
				if (item_q.mode == MODE_HOP) begin
					div_start = 1'b1;
					state_d   = S_QUO_WAIT;
				end else if (item_q.mode > MODE_READ_SHARE) begin
					res_we        = 1'b1;
					res_d.ignored = 1'b1;
					state_d       = S_EMIT;
				end else if (ch_out_of_range) begin
					res_we                 = 1'b1;
					res_d.selected_channel = item_q.channel;
					res_d.ignored          = 1'b1;
					state_d                = S_EMIT;
				end else begin
					state_d = S_UPDATE;
				end
			end
			S_QUO_WAIT: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = div_quotient ^ hop_seed_q;
					div_divisor  = DIV_W'(n_eff);
					state_d      = S_MOD_WAIT;
				end
			end
			S_MOD_WAIT: begin
				if (div_done) begin
					issue_idx_d = AW'(div_remainder);
					issue_cnt_d = '0;
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				if (chk_vld_s1 && rd_data_q == ST_GOOD) begin
					res_we                 = 1'b1;
					res_d.selected_channel = 10'(chk_idx_s1);
					res_d.found_good       = 1'b1;
					res_d.channel_status   = ST_GOOD;
					res_d.share_bit        = 1'b1;
					state_d                = S_EMIT;
				end else if (issue_cnt_q == n_eff) begin
					if (!chk_vld_s1) begin
						state_d = S_FB_READ;
					end
				end else begin
					rd_addr     = issue_idx_q;
					chk_vld_d   = 1'b1;
					issue_idx_d = issue_idx_inc;
					issue_cnt_d = issue_cnt_q + NW'(1);
				end
			end
			S_FB_READ: begin
				rd_addr = fb_addr;
				if (fb_in_range) begin
					state_d = S_FB_CHECK;
				end else begin
					res_we                 = 1'b1;
					res_d.selected_channel = fallback_channel_q;
					res_d.channel_status   = ST_GOOD;
					res_d.share_bit        = 1'b1;
					state_d                = S_EMIT;
				end
			end
			S_FB_CHECK: begin
				res_we                 = 1'b1;
				res_d.selected_channel = fallback_channel_q;
				res_d.channel_status   = rd_data_q;
				res_d.share_bit        = rd_data_q != ST_BAD_LOCAL;
				state_d                = S_EMIT;
			end
			S_UPDATE: begin
				wr_en                  = 1'b1;
				wr_addr                = ch_addr;
				wr_data                = upd_st;
				res_we                 = 1'b1;
				res_d.selected_channel = item_q.channel;
				res_d.channel_status   = upd_st;
				res_d.share_bit        = upd_st != ST_BAD_LOCAL;
				state_d                = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = ((state_q == S_IDLE) && !in_valid) || (state_q == S_CLEAR);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= S_CLEAR;
			clr_idx_q          <= '0;
			issue_idx_q        <= '0;
			issue_cnt_q        <= '0;
			chk_vld_s1         <= 1'b0;
			out_valid_q        <= 1'b0;
			hop_interval_q     <= 16'd47;
			hop_seed_q         <= 32'd0;
			channels_in_use_q  <= 11'd665;
			fallback_channel_q <= 10'd647;
		end else begin
			state_q     <= state_d;
			clr_idx_q   <= clr_idx_d;
			issue_idx_q <= issue_idx_d;
			issue_cnt_q <= issue_cnt_d;
			chk_vld_s1  <= chk_vld_d;
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_HOP_INTERVAL:     hop_interval_q     <= cfg_data[15:0];
					CFG_HOP_SEED:         hop_seed_q         <= cfg_data[31:0];
					CFG_CHANNELS_IN_USE:  channels_in_use_q  <= cfg_data[10:0];
					CFG_FALLBACK_CHANNEL: fallback_channel_q <= cfg_data[9:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		if (res_we) begin
			res_q <= res_d;
		end
		if (emit_load) begin
			out_q <= res_q;
		end
		chk_idx_s1 <= issue_idx_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	`HCMS_ASSERT_IMPL(a_scan_index_in_range, chk_vld_s1, chk_idx_s1 < n_eff, "scan index beyond channel count")
	`HCMS_ASSERT_IMPL(a_scan_count_bounded, state_q == S_SCAN, issue_cnt_q <= n_eff, "scan issued too many reads")
	`HCMS_ASSERT_IMPL(a_update_in_range, wr_en && state_q != S_CLEAR, wr_addr < n_eff, "status write beyond channel count")
	`HCMS_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state_q == S_DISPATCH, "accepted transaction not dispatched")
	`HCMS_ASSERT_NEXT(a_emit_shows_result, emit_load, out_valid_q, "result not presented after emit")

endmodule

/* tb/hop_channel_map_selector_checker.sv */
module hop_channel_map_selector_checker
	import hcms_pkg::*;
#(
	parameter int MAX_CHANNELS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_item_t            out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 closing,
	output int                   pending,
	output int                   failures
);

	logic [1:0]  map_status [MAX_CHANNELS];
	logic [15:0] interval_reg;
	logic [31:0] seed_reg;
	logic [10:0] count_reg;
	logic [9:0]  fallback_reg;
	out_item_t   expected_q [$];
	int          mismatches;

	assign failures = mismatches + (closing ? pending : 0);

	function automatic out_item_t apply_map_item(in_item_t it);
		out_item_t   r;
		logic [31:0] n;
		logic [31:0] divisor;
		logic [31:0] quotient;
		logic [31:0] start;
		logic [31:0] idx;
		logic [1:0]  st;
		bit          hit;
		r = '0;
		n = {21'd0, count_reg};
		if (n == 0) begin
			n = 1;
		end
		if (n > MAX_CHANNELS) begin
			n = MAX_CHANNELS;
		end
		if (it.mode > MODE_READ_SHARE) begin
			r.ignored = 1'b1;
			return r;
		end
		if (it.mode == MODE_HOP) begin
			divisor = (interval_reg == 16'd0) ? 32'd1 : {16'd0, interval_reg};
			quotient = {15'd0, it.shared_time} / divisor;
			start = (quotient ^ seed_reg) % n;
			hit = 1'b0;
			for (int i = 0; i < n && !hit; i++) begin
				idx = start + i;
				if (idx >= n) begin
					idx = idx - n;
				end
				if (map_status[idx] == ST_GOOD) begin
					r.selected_channel = idx[9:0];
					r.found_good = 1'b1;
					r.channel_status = ST_GOOD;
					r.share_bit = 1'b1;
					hit = 1'b1;
				end
			end
			if (!hit) begin
				st = ({22'd0, fallback_reg} < n) ? map_status[fallback_reg] : ST_GOOD;
				r.selected_channel = fallback_reg;
				r.channel_status = st;
				r.share_bit = (st != ST_BAD_LOCAL);
			end
			return r;
		end
		r.selected_channel = it.channel;
		if ({22'd0, it.channel} >= n) begin
			r.ignored = 1'b1;
			return r;
		end
		st = map_status[it.channel];
		case (it.mode)
			MODE_GOOD: begin
				st = ST_GOOD;
			end
			MODE_BAD_LOCAL: begin
				st = (st == ST_BAD_REMOTE) ? ST_BAD_BOTH : ST_BAD_LOCAL;
			end
			MODE_BAD_REMOTE: begin
				st = (st == ST_BAD_LOCAL) ? ST_BAD_BOTH : ST_BAD_REMOTE;
			end
			MODE_MERGE: begin
				if (!it.remote_good) begin
					if (st == ST_GOOD) begin
						st = ST_BAD_REMOTE;
					end else if (st == ST_BAD_LOCAL) begin
						st = ST_BAD_BOTH;
					end
				end
			end
			default: begin
			end
		endcase
		map_status[it.channel] = st;
		r.channel_status = st;
		r.share_bit = (st != ST_BAD_LOCAL);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				map_status[i] = ST_GOOD;
			end
			interval_reg <= 16'd47;
			seed_reg <= 32'd0;
			count_reg <= 11'd665;
			fallback_reg <= 10'd647;
			expected_q.delete();
			pending <= 0;
			mismatches <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_HOP_INTERVAL:     interval_reg <= cfg_data[15:0];
					CFG_HOP_SEED:         seed_reg <= cfg_data;
					CFG_CHANNELS_IN_USE:  count_reg <= cfg_data[10:0];
					CFG_FALLBACK_CHANNEL: fallback_reg <= cfg_data[9:0];
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					if (mismatches < 10) begin
						$display("Unexpected result transaction: sel=%0d found=%0d status=%0d share=%0d ign=%0d",
							out_data.selected_channel, out_data.found_good,
							out_data.channel_status, out_data.share_bit, out_data.ignored);
					end
					mismatches <= mismatches + 1;
				end else begin
					want = expected_q.pop_front();
					if (out_data.selected_channel !== want.selected_channel ||
						out_data.found_good !== want.found_good ||
						out_data.channel_status !== want.channel_status ||
						out_data.share_bit !== want.share_bit ||
						out_data.ignored !== want.ignored) begin
						if (mismatches < 10) begin
							$display("Mismatch: expected sel=%0d found=%0d status=%0d share=%0d ign=%0d",
								want.selected_channel, want.found_good,
								want.channel_status, want.share_bit, want.ignored);
							$display("          actual   sel=%0d found=%0d status=%0d share=%0d ign=%0d",
								out_data.selected_channel, out_data.found_good,
								out_data.channel_status, out_data.share_bit, out_data.ignored);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_q.push_back(apply_map_item(in_data));
			end
			pending <= expected_q.size();
		end
	end

endmodule

/* tb/hop_channel_map_selector_tb.sv */
module hop_channel_map_selector_tb;
	import hcms_pkg::*;

	localparam logic [2:0] MODE_RSVD_A = 3'd6;
	localparam logic [2:0] MODE_RSVD_B = 3'd7;
	localparam int         DRAIN_CYCLES = 1200;
	localparam int         ITEMS_PER_PHASE = 72;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic                 closing = 1'b0;
	logic                 tx_steady = 1'b0;
	logic                 rx_steady = 1'b0;
	int                   pending;
	int                   failures;
	int                   stall_left = 0;
	int                   rx_roll;

	hop_channel_map_selector #(
		.MAX_CHANNELS(1024)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	hop_channel_map_selector_checker #(
		.MAX_CHANNELS(1024)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.closing(closing),
		.pending(pending),
		.failures(failures)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (rx_steady) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 70) begin
				out_ready <= 1'b1;
			end else if (rx_roll < 96) begin
				out_ready <= 1'b0;
				stall_left <= $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b0;
				stall_left <= $urandom_range(10, 50);
			end
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end else if (roll < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input logic [2:0] mode, input logic [16:0] stime,
		input logic [9:0] ch, input logic rgood);
		in_item_t it;
		int gap;
		it.mode = mode;
		it.shared_time = stime;
		it.channel = ch;
		it.remote_good = rgood;
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic program_map(input logic [15:0] interval, input logic [31:0] seed,
		input logic [10:0] count, input logic [9:0] fallback);
		write_reg(CFG_HOP_INTERVAL, {16'($urandom), interval});
		write_reg(CFG_HOP_SEED, seed);
		write_reg(CFG_CHANNELS_IN_USE, {21'($urandom), count});
		write_reg(CFG_FALLBACK_CHANNEL, {22'($urandom), fallback});
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item(input int n_eff);
		int roll;
		logic [2:0] mode;
		logic [16:0] stime;
		logic [9:0] ch;
		roll = $urandom_range(0, 99);
		if (roll < 35) begin
			mode = MODE_HOP;
		end else if (roll < 50) begin
			mode = MODE_BAD_LOCAL;
		end else if (roll < 60) begin
			mode = MODE_BAD_REMOTE;
		end else if (roll < 72) begin
			mode = MODE_MERGE;
		end else if (roll < 80) begin
			mode = MODE_READ_SHARE;
		end else if (roll < 95) begin
			mode = MODE_GOOD;
		end else begin
			mode = $urandom_range(0, 1) ? MODE_RSVD_A : MODE_RSVD_B;
		end
		if ($urandom_range(0, 99) < 90) begin
			ch = 10'($urandom_range(0, n_eff - 1));
		end else begin
			ch = 10'($urandom);
		end
		if ($urandom_range(0, 99) < 85) begin
			stime = 17'($urandom_range(0, 86399));
		end else begin
			stime = 17'($urandom);
		end
		send_item(mode, stime, ch, 1'($urandom));
	endtask

	initial begin
		logic [10:0] count;
		logic [15:0] interval;
		logic [31:0] seed;
		logic [9:0] fallback;
		int n_eff;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration and the cleared map first.
		send_item(MODE_HOP, 17'd0, 10'd0, 1'b0);
		send_item(MODE_HOP, 17'd86399, 10'd0, 1'b0);
		send_item(MODE_HOP, 17'h1FFFF, 10'h3FF, 1'b1);
		send_item(MODE_BAD_LOCAL, 17'd0, 10'd0, 1'b0);
		send_item(MODE_BAD_REMOTE, 17'd0, 10'd0, 1'b0);
		send_item(MODE_READ_SHARE, 17'd0, 10'd0, 1'b0);
		send_item(MODE_GOOD, 17'd0, 10'd0, 1'b0);
		send_item(MODE_BAD_REMOTE, 17'd0, 10'd1, 1'b0);
		send_item(MODE_BAD_LOCAL, 17'd0, 10'd1, 1'b0);
		send_item(MODE_MERGE, 17'd0, 10'd2, 1'b0);
		send_item(MODE_BAD_LOCAL, 17'd0, 10'd3, 1'b0);
		send_item(MODE_MERGE, 17'd0, 10'd3, 1'b0);
		send_item(MODE_MERGE, 17'd0, 10'd4, 1'b1);
		send_item(MODE_READ_SHARE, 17'd0, 10'd664, 1'b0);
		send_item(MODE_GOOD, 17'd0, 10'd665, 1'b0);
		send_item(MODE_RSVD_A, 17'h1FFFF, 10'h3FF, 1'b1);
		send_item(MODE_RSVD_B, 17'd5, 10'd2, 1'b0);
		send_item(MODE_BAD_LOCAL, 17'd0, 10'd0, 1'b0);
		send_item(MODE_HOP, 17'd0, 10'd0, 1'b0);
		wait_drain();

		// Four channels, all bad: fallback inside the map, then a wrapped scan.
		program_map(16'd1, 32'd0, 11'd4, 10'd2);
		send_item(MODE_HOP, 17'd3, 10'd0, 1'b0);
		send_item(MODE_GOOD, 17'd0, 10'd1, 1'b0);
		send_item(MODE_HOP, 17'd3, 10'd0, 1'b0);
		wait_drain();

		// Zero interval and zero count, fallback outside the map.
		program_map(16'd0, 32'hFFFF_FFFF, 11'd0, 10'd1023);
		send_item(MODE_HOP, 17'd5, 10'd0, 1'b0);
		send_item(MODE_GOOD, 17'd0, 10'd1, 1'b0);
		wait_drain();

		// Count above the map size, largest interval.
		program_map(16'd65535, $urandom, 11'h7FF, 10'd0);
		send_item(MODE_HOP, 17'd86399, 10'd0, 1'b0);
		send_item(MODE_BAD_LOCAL, 17'd0, 10'd1023, 1'b0);
		wait_drain();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: count = 11'h7FF;
				1: count = 11'd1024;
				2: count = 11'd0;
				3: count = 11'd1;
				default: count = 11'($urandom_range(2, 16));
			endcase
			n_eff = (count == 0) ? 1 : ((count > 1024) ? 1024 : int'(count));
			case (p % 4)
				0: interval = 16'd0;
				1: interval = 16'd65535;
				2: interval = 16'd1;
				default: interval = 16'($urandom_range(1, 3000));
			endcase
			case (p % 3)
				0: seed = 32'd0;
				1: seed = 32'hFFFF_FFFF;
				default: seed = $urandom;
			endcase
			case (p % 4)
				0: fallback = 10'd0;
				1: fallback = 10'd1023;
				2: fallback = 10'($urandom_range(0, n_eff - 1));
				default: fallback = 10'($urandom);
			endcase
			tx_steady <= (p % 3 == 1);
			rx_steady <= (p % 4 == 2);
			program_map(interval, seed, count, fallback);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				random_item(n_eff);
				if ($urandom_range(0, 59) == 0) begin
					wait_drain();
				end
			end
			wait_drain();
		end

		tx_steady <= 1'b0;
		rx_steady <= 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		closing <= 1'b1;
		@(posedge clk);
		if (failures == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#6000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
